// ===== src/b64e_pkg.sv =====
// Types, constants and the alphabet lookup shared by the base64 encoder.
`default_nettype none
package b64e_pkg;

    localparam logic [1:0] MODE_STANDARD = 2'd0;
    localparam logic [1:0] MODE_MIME     = 2'd1;
    localparam logic [1:0] MODE_URLSAFE  = 2'd2;

    localparam logic       CFG_MODE        = 1'b0;
    localparam logic       CFG_LINE_LENGTH = 1'b1;

    localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
    localparam int         MAX_CHARS         = 6;

    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_LF      = 8'd10;
    localparam logic [7:0] CHAR_PAD     = 8'd61;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_PLUS    = 8'd43;
    localparam logic [7:0] CHAR_SLASH   = 8'd47;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_UNDER   = 8'd95;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_text;
    } t_out;

    typedef struct packed {
        logic [7:0] held0;
        logic [7:0] held1;
        logic [1:0] group_fill;
        logic [7:0] line_chars;
    } t_enc;

    function automatic logic [7:0] b64_sym(input logic [5:0] v, input logic url);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = CHAR_UPPER_A + {2'b00, v};
        end else if (v < 6'd52) begin
            r = CHAR_LOWER_A + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = CHAR_ZERO + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = url ? CHAR_MINUS : CHAR_PLUS;
        end else begin
            r = url ? CHAR_UNDER : CHAR_SLASH;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/b64e_fmt.sv =====
// Group formatter: turns one byte and the held bytes into up to six characters.
`default_nettype none
module b64e_fmt
    import b64e_pkg::*;
(
    input  wire t_in              i_in,
    input  wire t_enc             i_st,
    input  wire logic [1:0]       i_mode,
    input  wire logic [7:0]       i_line_length,
    output t_out [MAX_CHARS-1:0]  o_chars,
    output logic [2:0]            o_count,
    output t_enc                  o_st
);

    logic       url;
    logic       mime;
    logic [7:0] b;
    logic [7:0] a;
    logic [7:0] m;
    logic [8:0] nxt;
    logic       last;

    always_comb begin
        url  = (i_mode == MODE_URLSAFE);
        mime = (i_mode == MODE_MIME);
        b    = i_in.data_byte;
        last = i_in.final_byte;
        a    = i_st.held0;
        m    = i_st.held1;
        nxt  = {1'b0, i_st.line_chars} + 9'd4;

        o_st    = i_st;
        o_count = 3'd0;
        for (int i = 0; i < MAX_CHARS; i++) begin
            o_chars[i].out_char = CHAR_PAD;
        end

        if (i_st.group_fill[1]) begin
            o_chars[0].out_char = b64_sym(a[7:2], url);
            o_chars[1].out_char = b64_sym({a[1:0], m[7:4]}, url);
            o_chars[2].out_char = b64_sym({m[3:0], b[7:6]}, url);
            o_chars[3].out_char = b64_sym(b[5:0], url);
            o_count = 3'd4;
            if (mime) begin
                if (nxt >= {1'b0, i_line_length}) begin
                    o_chars[4].out_char = CHAR_CR;
                    o_chars[5].out_char = CHAR_LF;
                    o_count             = 3'd6;
                    o_st.line_chars     = 8'd0;
                end else begin
                    o_st.line_chars = nxt[7:0];
                end
            end
            o_st.group_fill = 2'd0;
        end else if (!last) begin
            if (i_st.group_fill[0]) begin
                o_st.held1 = b;
            end else begin
                o_st.held0 = b;
            end
            o_st.group_fill = i_st.group_fill + 2'd1;
        end else if (!i_st.group_fill[0]) begin
            o_chars[0].out_char = b64_sym(b[7:2], url);
            o_chars[1].out_char = b64_sym({b[1:0], 4'b0000}, url);
            o_count = 3'd4;
        end else begin
            o_chars[0].out_char = b64_sym(a[7:2], url);
            o_chars[1].out_char = b64_sym({a[1:0], b[7:4]}, url);
            o_chars[2].out_char = b64_sym({b[3:0], 2'b00}, url);
            o_count = 3'd4;
        end

        for (int i = 0; i < MAX_CHARS; i++) begin
            o_chars[i].end_of_text = last && ((3'(i) + 3'd1) == o_count);
        end

        if (last) begin
            o_st.group_fill = 2'd0;
            o_st.line_chars = 8'd0;
        end
    end

endmodule
`default_nettype wire

// ===== src/base64_stream_encoder.sv =====
// Top level of the base64 stream encoder: input register, formatter, character buffer.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_data : t_in  (data_byte, final_byte)
//   output   out        o_valid / i_stall    o_data : t_out (out_char, end_of_text)
//   config   in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One byte enters per cycle while o_stall is low; a byte that completes a group or
// ends the message loads 4 or 6 characters into a six-entry buffer that drains one
// word per cycle while i_stall is low, so the stream rate is set by the
// single-character output port.
// Synchronous active-low reset empties both stages and restores mode 0, length 76.
// A stall on the output holds the buffer and backs up into o_stall.
`default_nettype none
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    logic                 r_in_vld;
    logic                 n_in_vld;
    t_in                  r_in;
    t_enc                 r_st;
    t_enc                 n_st;
    logic [1:0]           r_mode;
    logic [7:0]           r_line_length;
    t_out [MAX_CHARS-1:0] r_buf;
    t_out [MAX_CHARS-1:0] n_buf;
    logic [2:0]           r_cnt;
    logic [2:0]           n_cnt;

    t_out [MAX_CHARS-1:0] f_chars;
    logic [2:0]           f_count;
    t_enc                 f_st;

    logic in_take;
    logic out_take;
    logic load_ok;
    logic adv;

    b64e_fmt u_fmt (
        .i_in          (r_in),
        .i_st          (r_st),
        .i_mode        (r_mode),
        .i_line_length (r_line_length),
        .o_chars       (f_chars),
        .o_count       (f_count),
        .o_st          (f_st)
    );

    always_comb begin
        out_take = (r_cnt != 3'd0) && !i_stall;
        load_ok  = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && out_take);
        adv      = r_in_vld && ((f_count == 3'd0) || load_ok);
        o_stall  = r_in_vld && !adv;
        in_take  = i_valid && !o_stall;

        n_in_vld = in_take ? 1'b1 : (adv ? 1'b0 : r_in_vld);
        n_st     = adv ? f_st : r_st;

        n_buf = r_buf;
        n_cnt = r_cnt;
        if (adv && (f_count != 3'd0)) begin
            n_buf = f_chars;
            n_cnt = f_count;
        end else if (out_take) begin
            for (int i = 0; i < MAX_CHARS - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - 3'd1;
        end

        o_valid = (r_cnt != 3'd0);
        o_data  = r_buf[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_cnt         <= 3'd0;
            r_st          <= '0;
            r_mode        <= MODE_STANDARD;
            r_line_length <= LINE_LENGTH_RESET;
        end else begin
            r_in_vld <= n_in_vld;
            r_cnt    <= n_cnt;
            r_st     <= n_st;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MODE) begin
                    r_mode <= i_cfg_data[1:0];
                end else begin
                    r_line_length <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_data;
        end
        r_buf <= n_buf;
    end

endmodule
`default_nettype wire
